### hw/rtl/rgb7_pkg.sv
package rgb7_pkg;

    localparam int PIX_W   = 8;   // one colour component
    localparam int FIELD_W = 10;  // one channel of a stored error word, in 1/16 units
    localparam int ERR_W   = 6;   // integer quantisation error of one channel
    localparam int WORD_W  = 3 * FIELD_W;
    localparam int CODE_W  = 7;
    localparam int INC_W   = 11;  // stored error plus seven times the right carry

    localparam int RED_BITS   = 2;
    localparam int GREEN_BITS = 3;
    localparam int BLUE_BITS  = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd1;

    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RESET = 11'd256;

    // Per-pixel controls shared by the three channel lanes.
    typedef struct packed {
        logic dither;
        logic col_gt0;
    } lane_ctrl_t;

endpackage

### hw/rtl/rgb7_ram.sv
module rgb7_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/rgb7_lane.sv
module rgb7_lane #(
    parameter int CODE_BITS = 2
) (
    input  logic [rgb7_pkg::PIX_W-1:0]   pixel_i,
    input  logic [rgb7_pkg::FIELD_W-1:0] store_i,
    input  logic [rgb7_pkg::ERR_W-1:0]   right_i,
    input  logic [rgb7_pkg::FIELD_W-1:0] pending_i,
    input  rgb7_pkg::lane_ctrl_t         ctrl_i,
    output logic [CODE_BITS-1:0]         code_o,
    output logic [rgb7_pkg::ERR_W-1:0]   err_o,
    output logic [rgb7_pkg::FIELD_W-1:0] left_o,
    output logic [rgb7_pkg::FIELD_W-1:0] pend_o
);

    logic [rgb7_pkg::INC_W-1:0]   right_term;
    logic [rgb7_pkg::INC_W-1:0]   inc;
    logic [rgb7_pkg::PIX_W:0]     sum;
    logic [rgb7_pkg::PIX_W-1:0]   value;
    logic [rgb7_pkg::ERR_W-1:0]   prev;

    always_comb begin
        right_term = ctrl_i.col_gt0 ?
                     rgb7_pkg::INC_W'(right_i) * rgb7_pkg::INC_W'(7) : '0;
        inc = rgb7_pkg::INC_W'(store_i) + right_term;
        // Only the integer part of the diffused error is added.
        sum = (rgb7_pkg::PIX_W + 1)'(pixel_i)
            + (rgb7_pkg::PIX_W + 1)'(inc[rgb7_pkg::INC_W-1:4]);
        if (!ctrl_i.dither) begin
            value = pixel_i;
        end else if (sum[rgb7_pkg::PIX_W]) begin
            value = '1;
        end else begin
            value = sum[rgb7_pkg::PIX_W-1:0];
        end
        err_o = ctrl_i.dither ?
                rgb7_pkg::ERR_W'(value[rgb7_pkg::PIX_W-1-CODE_BITS:0]) : '0;
        prev   = ctrl_i.col_gt0 ? right_i : '0;
        left_o = pending_i
               + rgb7_pkg::FIELD_W'(err_o) * rgb7_pkg::FIELD_W'(3);
        pend_o = rgb7_pkg::FIELD_W'(prev)
               + rgb7_pkg::FIELD_W'(err_o) * rgb7_pkg::FIELD_W'(5);
        code_o = value[rgb7_pkg::PIX_W-1 -: CODE_BITS];
    end

endmodule

### hw/rtl/rgb7_error_diffusion_quantizer.sv
// Error-diffusion quantiser from 24-bit RGB to a 7-bit code (red 2, green 3, blue 2 bits,
// red in the top bits). Pixels arrive in raster order, one per transaction, with tuser
// marking the first pixel of a frame; every pixel yields exactly one code, in order. With
// dithering on, quantisation error is spread with Floyd-Steinberg weights into the next
// pixel and into the next row, which is held in a one-line error memory of MAX_LINE_WIDTH
// words. The block takes one pixel per clock whenever the output side is ready: the line
// memory is read in the cycle a pixel is accepted and written for each pixel but the first
// of a row wider than one, the extra write at the end of a row going out in the following
// cycle; results written to the memory in the same cycle as a read are forwarded. A pixel's
// code passes the processing stage, then the output register. No clearing pass is needed
// after reset: the first row of each frame uses no stored error. Configuration (index 0
// dither enable, index 1 line width) should be written only while no pixel is in flight.
module rgb7_error_diffusion_quantizer #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: red [7:0], green [15:8], blue [23:16]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,
    // s_tuser: frame_start [0]
    input  logic [0:0]                         s_tuser,
    // m_tdata: color_code [6:0], zero [7]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgb7_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgb7_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW   = $clog2(MAX_LINE_WIDTH);
    localparam int LWW  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CMPW = (LWW > rgb7_pkg::CFG_DATA_W) ? LWW : rgb7_pkg::CFG_DATA_W;
    localparam int FW   = rgb7_pkg::FIELD_W;
    localparam int EW   = rgb7_pkg::ERR_W;
    localparam int WW   = rgb7_pkg::WORD_W;
    localparam logic [CMPW-1:0] MAX_EXT  = CMPW'(MAX_LINE_WIDTH);
    localparam logic [AW-1:0]   MAX_LAST = AW'(MAX_LINE_WIDTH - 1);

    // Configuration.
    logic                            dither_reg;
    logic [rgb7_pkg::CFG_DATA_W-1:0] line_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_reg     <= 1'b1;
            line_width_reg <= rgb7_pkg::LINE_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rgb7_pkg::CFG_DITHER_ENABLE: dither_reg     <= cfg_data[0];
                rgb7_pkg::CFG_LINE_WIDTH:    line_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective last column of a row.
    logic [CMPW-1:0] lw_ext;
    logic [AW-1:0]   last_col;

    always_comb begin
        lw_ext = CMPW'(line_width_reg);
        if (lw_ext == '0) begin
            last_col = '0;
        end else if (lw_ext > MAX_EXT) begin
            last_col = MAX_LAST;
        end else begin
            last_col = AW'(lw_ext - CMPW'(1));
        end
    end

    // Handshake: the processing stage and the output register move together.
    logic advance;
    logic accept;
    logic b_fire;
    logic b_valid_reg;
    logic m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;
    assign b_fire   = advance && b_valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Column tracking at acceptance.
    logic [AW-1:0] column_reg, column_next;
    logic          first_row_reg, first_row_next;
    logic [AW-1:0] col;
    logic          first_cur;
    logic          last;

    always_comb begin
        if (s_tuser[0]) begin
            col       = '0;
            first_cur = 1'b1;
        end else begin
            col       = (column_reg >= last_col) ? last_col : column_reg;
            first_cur = first_row_reg;
        end
        last           = (col == last_col);
        column_next    = last ? '0 : col + AW'(1);
        first_row_next = last ? 1'b0 : first_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
        end else if (accept) begin
            column_reg    <= column_next;
            first_row_reg <= first_row_next;
        end
    end

    // Line memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [WW-1:0] ram_rdata;

    rgb7_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col),
        .rdata (ram_rdata)
    );

    // Processing stage registers.
    logic [23:0]   b_pixel_reg;
    logic [AW-1:0] b_col_reg;
    logic          b_col_gt0_reg;
    logic          b_last_reg;
    logic          b_first_reg;
    logic          b_fwd_hit_reg;
    logic [WW-1:0] b_fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg  <= accept;
            m_tvalid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pixel_reg    <= s_tdata;
            b_col_reg      <= col;
            b_col_gt0_reg  <= (col != '0);
            b_last_reg     <= last;
            b_first_reg    <= first_cur;
            // The memory returns old data when it is written in the read cycle.
            b_fwd_hit_reg  <= ram_we && (ram_waddr == col);
            b_fwd_data_reg <= ram_wdata;
        end
    end

    // Channel lanes.
    logic [WW-1:0]     store_word;
    logic [3*EW-1:0]   right_reg, right_next;
    logic [WW-1:0]     below_reg, below_next;
    logic [3*EW-1:0]   err_word;
    logic [WW-1:0]     left_word;
    logic [WW-1:0]     pend_word;
    logic [rgb7_pkg::RED_BITS-1:0]   red_code;
    logic [rgb7_pkg::GREEN_BITS-1:0] green_code;
    logic [rgb7_pkg::BLUE_BITS-1:0]  blue_code;
    rgb7_pkg::lane_ctrl_t            lane_ctrl;

    assign store_word        = b_first_reg   ? '0 :
                               b_fwd_hit_reg ? b_fwd_data_reg : ram_rdata;
    assign lane_ctrl.dither  = dither_reg;
    assign lane_ctrl.col_gt0 = b_col_gt0_reg;

    rgb7_lane #(.CODE_BITS(rgb7_pkg::RED_BITS)) u_lane_red (
        .pixel_i   (b_pixel_reg[7:0]),
        .store_i   (store_word[FW-1:0]),
        .right_i   (right_reg[EW-1:0]),
        .pending_i (below_reg[FW-1:0]),
        .ctrl_i    (lane_ctrl),
        .code_o    (red_code),
        .err_o     (err_word[EW-1:0]),
        .left_o    (left_word[FW-1:0]),
        .pend_o    (pend_word[FW-1:0])
    );

    rgb7_lane #(.CODE_BITS(rgb7_pkg::GREEN_BITS)) u_lane_green (
        .pixel_i   (b_pixel_reg[15:8]),
        .store_i   (store_word[2*FW-1:FW]),
        .right_i   (right_reg[2*EW-1:EW]),
        .pending_i (below_reg[2*FW-1:FW]),
        .ctrl_i    (lane_ctrl),
        .code_o    (green_code),
        .err_o     (err_word[2*EW-1:EW]),
        .left_o    (left_word[2*FW-1:FW]),
        .pend_o    (pend_word[2*FW-1:FW])
    );

    rgb7_lane #(.CODE_BITS(rgb7_pkg::BLUE_BITS)) u_lane_blue (
        .pixel_i   (b_pixel_reg[23:16]),
        .store_i   (store_word[3*FW-1:2*FW]),
        .right_i   (right_reg[3*EW-1:2*EW]),
        .pending_i (below_reg[3*FW-1:2*FW]),
        .ctrl_i    (lane_ctrl),
        .code_o    (blue_code),
        .err_o     (err_word[3*EW-1:2*EW]),
        .left_o    (left_word[3*FW-1:2*FW]),
        .pend_o    (pend_word[3*FW-1:2*FW])
    );

    // Merging stage: carries, memory writes and the packed code.
    logic          b_write;
    logic          tail_valid_reg, tail_valid_next;
    logic [AW-1:0] tail_addr_reg;
    logic [WW-1:0] tail_data_reg;

    always_comb begin
        right_next      = right_reg;
        below_next      = below_reg;
        tail_valid_next = 1'b0;
        b_write         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = tail_addr_reg;
        ram_wdata       = tail_data_reg;
        if (b_fire) begin
            if (b_last_reg) begin
                right_next = '0;
                below_next = '0;
            end else begin
                right_next = err_word;
                below_next = pend_word;
            end
            if (b_col_gt0_reg) begin
                b_write   = 1'b1;
                ram_waddr = b_col_reg - AW'(1);
                ram_wdata = left_word;
                // The end-of-row word follows in the next cycle.
                tail_valid_next = b_last_reg;
            end else if (b_last_reg) begin
                b_write   = 1'b1;
                ram_waddr = b_col_reg;
                ram_wdata = pend_word;
            end
        end
        ram_we = b_write || tail_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_reg      <= '0;
            below_reg      <= '0;
            tail_valid_reg <= 1'b0;
        end else begin
            right_reg      <= right_next;
            below_reg      <= below_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tail_valid_next) begin
            tail_addr_reg <= b_col_reg;
            tail_data_reg <= pend_word;
        end
        if (b_fire) begin
            m_tdata_reg <= {1'b0, red_code, green_code, blue_code};
        end
    end

    // The deferred end-of-row write never meets a write from the processing stage.
    a_tail_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_valid_reg |-> !b_write)
        else $error("end-of-row write collides with a pixel write");

    // The deferred write only ever targets a column beyond the first.
    a_tail_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_valid_reg |-> (tail_addr_reg != '0))
        else $error("end-of-row write at column zero");

    // After the last pixel of a row is accepted the next row starts at column zero.
    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last) |=> (column_reg == '0) && !first_row_reg)
        else $error("column count did not wrap at the end of a row");

    // A transaction that completes processing always lands in the output register.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        b_fire |=> m_tvalid_reg)
        else $error("processed pixel produced no result");

endmodule

### test/tb_rgb7_error_diffusion_quantizer.sv
`timescale 1ns / 100ps

module tb_rgb7_error_diffusion_quantizer;

    localparam int LINE_MAX    = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int FW          = rgb7_pkg::FIELD_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
        logic       wait_drain;
    } pixel_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata   = '0;
    logic [0:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rgb7_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rgb7_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state and the configuration it sees.
    logic [rgb7_pkg::WORD_W-1:0]     err_line [LINE_MAX];
    logic [rgb7_pkg::WORD_W-1:0]     carry_right  = '0;
    logic [rgb7_pkg::WORD_W-1:0]     pend_below   = '0;
    int unsigned                     col_pos      = 0;
    bit                              on_first_row = 1'b1;
    bit                              dither_on    = 1'b1;
    logic [rgb7_pkg::CFG_DATA_W-1:0] width_reg    = rgb7_pkg::LINE_WIDTH_RESET;

    pixel_t                          pending_pixels [$];
    logic [rgb7_pkg::CODE_W-1:0]     expected_codes [$];
    pixel_t                          next_pixel;
    logic [rgb7_pkg::CODE_W-1:0]     want_code;
    int                              codes_outstanding = 0;
    int                              items_queued      = 0;
    int                              error_count       = 0;
    int                              cycle_count       = 0;
    int                              send_idle_pct     = 0;
    int                              recv_idle_pct     = 0;
    bit                              force_frame       = 1'b0;

    rgb7_error_diffusion_quantizer #(
        .MAX_LINE_WIDTH(LINE_MAX)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned eff_width(input logic [rgb7_pkg::CFG_DATA_W-1:0] w);
        if (w < 1)
            return 1;
        if (w > LINE_MAX)
            return LINE_MAX;
        return 32'(w);
    endfunction

    // Quantises one pixel and advances the error diffusion state.
    function automatic logic [rgb7_pkg::CODE_W-1:0] quantise_pixel(input logic [7:0] red,
                                                                   input logic [7:0] green,
                                                                   input logic [7:0] blue,
                                                                   input logic frame_start);
        int unsigned                 w;
        int unsigned                 c;
        int unsigned                 v;
        int unsigned                 inc;
        int unsigned                 prev;
        int                          ch;
        int unsigned                 px [3];
        int unsigned                 err [3];
        logic [7:0]                  quant [3];
        logic [7:0]                  keep;
        logic [rgb7_pkg::WORD_W-1:0] stored;
        logic [rgb7_pkg::WORD_W-1:0] left_word;
        logic [rgb7_pkg::WORD_W-1:0] next_pend;
        bit                          last;

        px[0] = 32'(red);
        px[1] = 32'(green);
        px[2] = 32'(blue);
        if (frame_start) begin
            col_pos      = 0;
            on_first_row = 1'b1;
            carry_right  = '0;
            pend_below   = '0;
        end
        w = eff_width(width_reg);
        c = (col_pos >= w) ? w - 1 : col_pos;
        last = (c + 1 >= w);
        stored = on_first_row ? '0 : err_line[c];

        for (ch = 0; ch < 3; ch++) begin
            keep = (ch == 1) ? 8'hE0 : 8'hC0;
            v = px[ch];
            if (dither_on) begin
                inc = 32'(stored[ch*FW +: FW]);
                if (c > 0)
                    inc += 7 * 32'(carry_right[ch*FW +: FW]);
                v += inc >> 4;
                if (v > 255)
                    v = 255;
                err[ch] = v - (v & 32'(keep));
            end else begin
                err[ch] = 0;
            end
            quant[ch] = v[7:0];
        end

        left_word = '0;
        next_pend = '0;
        for (ch = 0; ch < 3; ch++) begin
            prev = (c > 0) ? 32'(carry_right[ch*FW +: FW]) : 0;
            left_word[ch*FW +: FW] = FW'(32'(pend_below[ch*FW +: FW]) + 3 * err[ch]);
            next_pend[ch*FW +: FW] = FW'(prev + 5 * err[ch]);
        end
        if (c > 0)
            err_line[c-1] = left_word;

        if (last) begin
            err_line[c]  = next_pend;
            carry_right  = '0;
            pend_below   = '0;
            col_pos      = 0;
            on_first_row = 1'b0;
        end else begin
            carry_right = '0;
            for (ch = 0; ch < 3; ch++)
                carry_right[ch*FW +: FW] = FW'(err[ch]);
            pend_below = next_pend;
            col_pos    = c + 1;
        end
        return {quant[0][7:6], quant[1][7:5], quant[2][7:6]};
    endfunction

    // Pixel driver: the prediction is taken when the transaction is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_codes.push_back(quantise_pixel(s_tdata[7:0], s_tdata[15:8],
                                                        s_tdata[23:16], s_tuser[0]));
            if (!s_tvalid || s_tready) begin
                if (pending_pixels.size() != 0 &&
                    (!pending_pixels[0].wait_drain || expected_codes.size() == 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    next_pixel = pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_pixel.blue, next_pixel.green, next_pixel.red};
                    s_tuser  <= next_pixel.frame_start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Code monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    $error("color_code: unexpected result 0x%02h",
                           m_tdata[rgb7_pkg::CODE_W-1:0]);
                    error_count++;
                end else begin
                    want_code = expected_codes.pop_front();
                    codes_outstanding--;
                    if (m_tdata[rgb7_pkg::CODE_W-1:0] !== want_code) begin
                        $error("color_code mismatch: expected 0x%02h, actual 0x%02h",
                               want_code, m_tdata[rgb7_pkg::CODE_W-1:0]);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic frame_start,
                              input logic wait_drain);
        pixel_t p;
        p.red         = red;
        p.green       = green;
        p.blue        = blue;
        p.frame_start = frame_start | force_frame;
        p.wait_drain  = wait_drain;
        force_frame   = 1'b0;
        pending_pixels.push_back(p);
        codes_outstanding++;
        items_queued++;
    endtask

    task automatic wait_idle();
        while (codes_outstanding != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [rgb7_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rgb7_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rgb7_pkg::CFG_DITHER_ENABLE)
            dither_on = val[0];
        else if (idx == rgb7_pkg::CFG_LINE_WIDTH)
            width_reg = val;
    endtask

    // A wider line would read store entries never written, so growth starts a new frame.
    task automatic set_config(input bit dither,
                              input logic [rgb7_pkg::CFG_DATA_W-1:0] width);
        int unsigned old_w;
        wait_idle();
        old_w = eff_width(width_reg);
        cfg_write(rgb7_pkg::CFG_DITHER_ENABLE, rgb7_pkg::CFG_DATA_W'(dither));
        cfg_write(rgb7_pkg::CFG_LINE_WIDTH, width);
        if (eff_width(width) > old_w)
            force_frame = 1'b1;
    endtask

    function automatic logic [7:0] random_component();
        logic [7:0] edges [8] = '{8'd31, 8'd32, 8'd63, 8'd64, 8'd191, 8'd192, 8'd223, 8'd224};
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return edges[$urandom_range(0, 7)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_segment();
        logic [rgb7_pkg::CFG_DATA_W-1:0] width;
        int unsigned                     w;
        int unsigned                     count;
        int                              i;
        case ($urandom_range(0, 11))
            0:       width = 11'd1;
            1:       width = 11'd0;
            2:       width = rgb7_pkg::CFG_DATA_W'($urandom_range(13, 80));
            3:       width = rgb7_pkg::CFG_DATA_W'($urandom_range(1025, 2047));
            4:       width = rgb7_pkg::CFG_DATA_W'($urandom_range(100, 1024));
            default: width = rgb7_pkg::CFG_DATA_W'($urandom_range(2, 12));
        endcase
        set_config($urandom_range(0, 3) != 0, width);
        w = eff_width(width);
        if (w <= 12)
            count = $urandom_range(w * 2 + 2, w * 6 + 4);
        else if (w <= 80)
            count = $urandom_range(w, w * 3);
        else
            count = $urandom_range(4, 40);
        for (i = 0; i < count; i++)
            push_pixel(random_component(), random_component(), random_component(),
                       $urandom_range(0, 79) == 0, $urandom_range(0, 149) == 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int target);
        int start;
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_queued;
        while (items_queued - start < target)
            run_segment();
    endtask

    initial begin
        int i;
        send_idle_pct = 34;
        recv_idle_pct = 57;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Ten pixels in rows of four, with maximal errors and clamping at full scale.
        set_config(1'b1, 11'd4);
        push_pixel(8'd63,  8'd31,  8'd63,  1'b1, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        push_pixel(8'd63,  8'd31,  8'd63,  1'b0, 1'b1);
        push_pixel(8'd200, 8'd100, 8'd50,  1'b0, 1'b0);
        push_pixel(8'd63,  8'd31,  8'd63,  1'b0, 1'b0);
        push_pixel(8'd255, 8'd0,   8'd0,   1'b0, 1'b0);
        push_pixel(8'd0,   8'd255, 8'd0,   1'b0, 1'b0);
        push_pixel(8'd0,   8'd0,   8'd255, 1'b0, 1'b0);
        push_pixel(8'd191, 8'd223, 8'd191, 1'b0, 1'b0);
        push_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
        // Width shrinks below the current column mid-row.
        set_config(1'b1, 11'd2);
        push_pixel(8'd63,  8'd31,  8'd63,  1'b0, 1'b0);
        push_pixel(8'd63,  8'd31,  8'd63,  1'b0, 1'b0);
        push_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
        // A width of zero behaves as a single column.
        set_config(1'b1, 11'd0);
        push_pixel(8'd63,  8'd31,  8'd63,  1'b0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        set_config(1'b0, 11'd1);
        push_pixel(8'd63,  8'd31,  8'd63,  1'b0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        // Width above the maximum is clamped.
        set_config(1'b1, 11'd2047);
        for (i = 0; i < 3; i++)
            push_pixel(8'd63, 8'd31, 8'd63, 1'b0, 1'b0);

        run_phase(34, 57, 380);
        run_phase(57, 34, 380);

        // One frame at full line width, then more random segments without idling.
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(1'b1, rgb7_pkg::CFG_DATA_W'(LINE_MAX));
        for (i = 0; i < LINE_MAX + 6; i++)
            push_pixel(random_component(), random_component(), random_component(),
                       i == 0, 1'b0);
        run_phase(0, 0, 60);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (expected_codes.size() != 0) begin
            $error("color_code: %0d expected results never arrived", expected_codes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### rgb7_error_diffusion_quantizer.f
hw/rtl/rgb7_pkg.sv
hw/rtl/rgb7_ram.sv
hw/rtl/rgb7_lane.sv
hw/rtl/rgb7_error_diffusion_quantizer.sv
test/tb_rgb7_error_diffusion_quantizer.sv
